// ----- rtl/sfla_pkg.sv -----
// ----------------------------------------------------------------------------
// Segregated free-list allocator package
// Shared widths, constants, item types, datapath commands and the size-class
// lookup used by the controller and the datapath.
// ----------------------------------------------------------------------------
package sfla_pkg;

  // Heap geometry.
  localparam int HEAP_WORDS  = 65536;
  localparam int WORD_AW     = $clog2(HEAP_WORDS);
  localparam int WORD_W      = 32;
  localparam int ADDR_W      = 18;
  localparam int SIZE_W      = 19;
  localparam int END_W       = 19;
  localparam int WALK_W      = 20;
  localparam int GROW_W      = 20;
  localparam int CHUNK_W     = 17;
  localparam int NUM_CLASSES = 12;
  localparam int CLS_W       = $clog2(NUM_CLASSES);

  localparam logic [END_W-1:0]   HEAP_BYTES    = END_W'(HEAP_WORDS * 4);
  localparam logic [SIZE_W-1:0]  MIN_BLOCK     = SIZE_W'(24);
  localparam logic [ADDR_W-1:0]  FIRST_PAYLOAD = ADDR_W'(16);
  localparam logic [CHUNK_W-1:0] RESET_CHUNK   = CHUNK_W'(2048);

  // Reset layout is written by a short sequence of word stores.
  localparam int INIT_LEN = 8;
  localparam int INIT_W   = $clog2(INIT_LEN);

  // Opcodes and result status codes.
  localparam logic OPC_ALLOC = 1'b0;
  localparam logic OPC_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // Upper size limit of each class; the last class takes everything larger.
  localparam logic [SIZE_W-1:0] CLASS_LIMIT [15] = '{
    SIZE_W'(24), SIZE_W'(48), SIZE_W'(72), SIZE_W'(96), SIZE_W'(120),
    SIZE_W'(240), SIZE_W'(480), SIZE_W'(960), SIZE_W'(1920), SIZE_W'(3840),
    SIZE_W'(7680), SIZE_W'(15360), SIZE_W'(30720), SIZE_W'(61440),
    SIZE_W'(122880)
  };

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] req_size;
    logic [ADDR_W-1:0] block_addr;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic [1:0]        status;
  } out_item_t;

  // One datapath micro-operation per cycle.
  typedef enum logic [5:0] {
    OP_NOP, OP_INIT, OP_ACCEPT, OP_IGNORE, OP_OOM,
    OP_FIT_HEAD, OP_FIT_TEST, OP_FIT_CHK, OP_FIT_NEXT,
    OP_GROW_SIZE, OP_GROW_HDR, OP_GROW_FTR, OP_GROW_EPI,
    OP_MRG_RD, OP_MRG_SZ, OP_MRG_PT, OP_MRG_NX, OP_MRG_PV, OP_MRG_HDR, OP_MRG_FTR,
    OP_RM_RD, OP_RM_CLS, OP_RM_PRED, OP_RM_NEXT, OP_RM_BACK,
    OP_PU_RD, OP_PU_CLS, OP_PU_LINK, OP_PU_BACK,
    OP_PL_RD, OP_PL_SZ, OP_PL_HDR, OP_PL_A_FTR, OP_PL_R_HDR, OP_PL_R_FTR, OP_PL_W_FTR,
    OP_WK_TEST, OP_WK_CHK, OP_FR_HDR, OP_FR_FTR, OP_OUT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [INIT_W-1:0] init_step;
  } cmd_t;

  // Decision flags returned by the datapath.
  typedef struct packed {
    logic is_free;
    logic req_zero;
    logic addr_zero;
    logic p_zero;
    logic cls_last;
    logic fit_ok;
    logic oom;
    logic next_free;
    logic prev_free;
    logic split;
    logic p_end;
    logic hit;
    logic hit_alloc;
    logic s_zero;
  } flags_t;

  // Size class of a block size.
  function automatic logic [CLS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
    logic [CLS_W-1:0] c;
    c = CLS_W'(NUM_CLASSES - 1);
    for (int i = NUM_CLASSES - 2; i >= 0; i--) begin
      if (size <= CLASS_LIMIT[i]) c = CLS_W'(i);
    end
    return c;
  endfunction

endpackage

// ----- rtl/segregated_free_list_allocator.sv -----
// Flow: an allocate searches the class lists for the first block that fits, then places it
// whole or splits it; when nothing fits, the heap grows and the new block merges with a
// free last block, or the allocate fails when the heap is full. A free walks the heap
// blocks from the first one to validate its address, then merges with free neighbors;
// a stalled result waits in the output register.
// Throughput: one item at a time. Reset: synchronous; an init sequence writes the heap.
// ----------------------------------------------------------------------------
// Segregated free-list allocator
// Serves allocate and free commands on a boundary-tagged heap held in block
// memory, with size-class free lists, block splitting and coalescing.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  sfla_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sfla_pkg::out_item_t          out_item,
  input  logic                         cfg_wr_en,
  input  logic [sfla_pkg::CHUNK_W-1:0] cfg_wr_data
);
  import sfla_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  // Command sequencer.
  sfla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .flags     (flags)
  );

  // Heap memory and work registers.
  sfla_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .flags       (flags),
    .in_item     (in_item),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule

// ----- rtl/sfla_dp.sv -----
// ----------------------------------------------------------------------------
// Allocator datapath
// Heap word memory, class list heads, heap end, work registers and the
// output register. Executes one micro-operation per cycle.
// ----------------------------------------------------------------------------
module sfla_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  sfla_pkg::cmd_t               cmd,
  output sfla_pkg::flags_t             flags,
  input  sfla_pkg::in_item_t           in_item,
  output sfla_pkg::out_item_t          out_item,
  input  logic                         cfg_wr_en,
  input  logic [sfla_pkg::CHUNK_W-1:0] cfg_wr_data
);
  import sfla_pkg::*;

  localparam logic [ADDR_W-1:0] INIT_ADDR [INIT_LEN] = '{
    ADDR_W'(0), ADDR_W'(4), ADDR_W'(8), ADDR_W'(int'(FIRST_PAYLOAD) - 4),
    ADDR_W'(int'(FIRST_PAYLOAD) + int'(RESET_CHUNK) - 8),
    ADDR_W'(int'(FIRST_PAYLOAD) + int'(RESET_CHUNK) - 4),
    ADDR_W'(FIRST_PAYLOAD), ADDR_W'(int'(FIRST_PAYLOAD) + 4)
  };
  localparam logic [WORD_W-1:0] INIT_DATA [INIT_LEN] = '{
    WORD_W'(0), WORD_W'(9), WORD_W'(9), WORD_W'(RESET_CHUNK),
    WORD_W'(RESET_CHUNK), WORD_W'(1), WORD_W'(0), WORD_W'(0)
  };

  // Byte address arithmetic wraps at the heap address width.
  function automatic logic [ADDR_W-1:0] off(input logic [WALK_W-1:0] base,
                                            input logic [WALK_W-1:0] plus,
                                            input logic [WALK_W-1:0] minus);
    return ADDR_W'(base + plus - minus);
  endfunction

  function automatic logic [WORD_W-1:0] tag(input logic [SIZE_W-1:0] size, input logic al);
    return WORD_W'(size) | WORD_W'(al);
  endfunction

  logic [WORD_W-1:0]  mem [HEAP_WORDS];
  logic [WORD_W-1:0]  rdata;
  logic [ADDR_W-1:0]  maddr;
  logic               mwe;
  logic [WORD_W-1:0]  mwdata;

  logic [ADDR_W-1:0]  heads [NUM_CLASSES];
  logic [END_W-1:0]   heap_end;
  logic [CHUNK_W-1:0] chunk;

  logic               opc;
  logic [ADDR_W-1:0]  areq, aaddr;
  logic [SIZE_W-1:0]  asize, size, s, ptag;
  logic [GROW_W-1:0]  g;
  logic [CLS_W-1:0]   cls, xc, hidx;
  logic [WALK_W-1:0]  p;
  logic [ADDR_W-1:0]  bp, nb, x, lpred, lnext, res;
  logic [1:0]         stat;

  logic [SIZE_W-1:0]  rsize, psize, rnd, asize_calc, gmax;
  logic [GROW_W-1:0]  g_calc;
  logic [ADDR_W-1:0]  head_rd;

  // Sizes as read from a tag word and from the saved previous footer.
  assign rsize   = {rdata[SIZE_W-1:3], 3'b000};
  assign psize   = {ptag[SIZE_W-1:3], 3'b000};
  assign hidx    = (cmd.op == OP_FIT_HEAD) ? cls : xc;
  assign head_rd = heads[hidx];

  // Request rounding and heap growth size.
  always_comb begin
    rnd        = (SIZE_W'(in_item.req_size) + SIZE_W'(15)) & ~SIZE_W'(7);
    asize_calc = (rnd < MIN_BLOCK) ? MIN_BLOCK : rnd;
    gmax       = (asize > SIZE_W'(chunk)) ? asize : SIZE_W'(chunk);
    g_calc     = ((GROW_W'(gmax) & ~GROW_W'(3)) + GROW_W'(7)) & ~GROW_W'(7);
  end

  // Decision flags for the controller.
  always_comb begin
    flags.is_free   = (opc == OPC_FREE);
    flags.req_zero  = (areq == '0);
    flags.addr_zero = (aaddr == '0);
    flags.p_zero    = (p == '0);
    flags.cls_last  = (cls == CLS_W'(NUM_CLASSES - 1));
    flags.fit_ok    = (rsize >= asize);
    flags.oom       = (g > GROW_W'(HEAP_BYTES - heap_end));
    flags.next_free = ~rdata[0];
    flags.prev_free = ~ptag[0];
    flags.split     = ((size - asize) >= MIN_BLOCK);
    flags.p_end     = (p >= WALK_W'(heap_end));
    flags.hit       = (p == WALK_W'(aaddr));
    flags.hit_alloc = rdata[0];
    flags.s_zero    = (rsize == '0);
  end

  // Memory port address and write data for each micro-operation.
  always_comb begin
    maddr  = '0;
    mwe    = 1'b0;
    mwdata = '0;
    unique case (cmd.op)
      OP_INIT: begin
        maddr  = INIT_ADDR[cmd.init_step];
        mwe    = 1'b1;
        mwdata = INIT_DATA[cmd.init_step];
      end
      OP_FIT_TEST: maddr = off(p, '0, WALK_W'(4));
      OP_FIT_CHK:  maddr = off(p, WALK_W'(4), '0);
      OP_GROW_HDR: begin
        maddr  = off(WALK_W'(heap_end), '0, WALK_W'(4));
        mwe    = 1'b1;
        mwdata = WORD_W'(g);
      end
      OP_GROW_FTR: begin
        maddr  = off(WALK_W'(bp), WALK_W'(g), WALK_W'(8));
        mwe    = 1'b1;
        mwdata = WORD_W'(g);
      end
      OP_GROW_EPI: begin
        maddr  = off(WALK_W'(bp), WALK_W'(g), WALK_W'(4));
        mwe    = 1'b1;
        mwdata = WORD_W'(1);
      end
      OP_MRG_RD: maddr = off(WALK_W'(bp), '0, WALK_W'(4));
      OP_MRG_SZ: maddr = off(WALK_W'(bp), '0, WALK_W'(8));
      OP_MRG_PT: maddr = off(WALK_W'(bp), WALK_W'(size), WALK_W'(4));
      OP_MRG_HDR: begin
        maddr  = off(WALK_W'(bp), '0, WALK_W'(4));
        mwe    = 1'b1;
        mwdata = tag(size, 1'b0);
      end
      OP_MRG_FTR: begin
        maddr  = off(WALK_W'(bp), WALK_W'(size), WALK_W'(8));
        mwe    = 1'b1;
        mwdata = tag(size, 1'b0);
      end
      OP_RM_RD:   maddr = off(WALK_W'(x), '0, WALK_W'(4));
      OP_RM_CLS:  maddr = x;
      OP_RM_PRED: maddr = off(WALK_W'(x), WALK_W'(4), '0);
      OP_RM_NEXT: begin
        maddr  = off(WALK_W'(lpred), WALK_W'(4), '0);
        mwe    = (lpred != '0);
        mwdata = WORD_W'(rdata[ADDR_W-1:0]);
      end
      OP_RM_BACK: begin
        maddr  = lnext;
        mwe    = (lnext != '0);
        mwdata = WORD_W'(lpred);
      end
      OP_PU_RD: maddr = off(WALK_W'(x), '0, WALK_W'(4));
      OP_PU_CLS: begin
        maddr = x;
        mwe   = 1'b1;
      end
      OP_PU_LINK: begin
        maddr  = off(WALK_W'(x), WALK_W'(4), '0);
        mwe    = 1'b1;
        mwdata = WORD_W'(head_rd);
      end
      OP_PU_BACK: begin
        maddr  = lnext;
        mwe    = (lnext != '0);
        mwdata = WORD_W'(x);
      end
      OP_PL_RD: maddr = off(WALK_W'(bp), '0, WALK_W'(4));
      OP_PL_HDR: begin
        maddr  = off(WALK_W'(bp), '0, WALK_W'(4));
        mwe    = 1'b1;
        mwdata = tag(flags.split ? asize : size, 1'b1);
      end
      OP_PL_A_FTR: begin
        maddr  = off(WALK_W'(bp), WALK_W'(asize), WALK_W'(8));
        mwe    = 1'b1;
        mwdata = tag(asize, 1'b1);
      end
      OP_PL_R_HDR: begin
        maddr  = off(WALK_W'(bp), WALK_W'(asize), WALK_W'(4));
        mwe    = 1'b1;
        mwdata = tag(size - asize, 1'b0);
      end
      OP_PL_R_FTR: begin
        maddr  = off(WALK_W'(bp), WALK_W'(size), WALK_W'(8));
        mwe    = 1'b1;
        mwdata = tag(size - asize, 1'b0);
      end
      OP_PL_W_FTR: begin
        maddr  = off(WALK_W'(bp), WALK_W'(size), WALK_W'(8));
        mwe    = 1'b1;
        mwdata = tag(size, 1'b1);
      end
      OP_WK_TEST: maddr = off(p, '0, WALK_W'(4));
      OP_FR_HDR: begin
        maddr  = off(WALK_W'(aaddr), '0, WALK_W'(4));
        mwe    = 1'b1;
        mwdata = tag(s, 1'b0);
      end
      OP_FR_FTR: begin
        maddr  = off(WALK_W'(aaddr), WALK_W'(s), WALK_W'(8));
        mwe    = 1'b1;
        mwdata = tag(s, 1'b0);
      end
      default: begin
        maddr  = '0;
        mwe    = 1'b0;
        mwdata = '0;
      end
    endcase
  end

  // Heap memory: one access per cycle, registered read data.
  always_ff @(posedge clk) begin
    if (mwe) mem[maddr[WORD_AW+1:2]] <= mwdata;
    rdata <= mem[maddr[WORD_AW+1:2]];
  end

  // List heads, heap end and the growth register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        heads[i] <= (CLS_W'(i) == class_of(SIZE_W'(RESET_CHUNK))) ? FIRST_PAYLOAD : '0;
      end
      heap_end <= END_W'(FIRST_PAYLOAD) + END_W'(RESET_CHUNK);
      chunk    <= RESET_CHUNK;
    end else begin
      if (cfg_wr_en) chunk <= cfg_wr_data;
      if (cmd.op == OP_GROW_EPI) heap_end <= heap_end + END_W'(g);
      if (cmd.op == OP_RM_NEXT && lpred == '0) heads[xc] <= rdata[ADDR_W-1:0];
      if (cmd.op == OP_PU_LINK) heads[xc] <= x;
    end
  end

  // Work registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        opc   <= in_item.opcode;
        areq  <= in_item.req_size;
        aaddr <= in_item.block_addr;
        asize <= asize_calc;
        cls   <= class_of(asize_calc);
        p     <= WALK_W'(FIRST_PAYLOAD);
        res   <= '0;
        stat  <= ST_DONE;
      end
      OP_IGNORE:   stat <= ST_IGNORED;
      OP_OOM:      stat <= ST_OOM;
      OP_FIT_HEAD: p <= WALK_W'(head_rd);
      OP_FIT_TEST: if (p == '0) cls <= cls + CLS_W'(1);
      OP_FIT_CHK:  if (flags.fit_ok) bp <= p[ADDR_W-1:0];
      OP_FIT_NEXT: p <= WALK_W'(rdata[ADDR_W-1:0]);
      OP_GROW_SIZE: g <= g_calc;
      OP_GROW_HDR: bp <= heap_end[ADDR_W-1:0];
      OP_MRG_SZ:   size <= rsize;
      OP_MRG_PT: begin
        ptag <= rdata[SIZE_W-1:0];
        nb   <= off(WALK_W'(bp), WALK_W'(size), '0);
      end
      OP_MRG_NX: begin
        if (flags.next_free) begin
          size <= size + rsize;
          x    <= nb;
        end
      end
      OP_MRG_PV: begin
        if (flags.prev_free) begin
          bp   <= off(WALK_W'(bp), '0, WALK_W'(psize));
          x    <= off(WALK_W'(bp), '0, WALK_W'(psize));
          size <= size + psize;
        end
      end
      OP_MRG_FTR:  x <= bp;
      OP_RM_CLS:   xc <= class_of(rsize);
      OP_RM_PRED:  lpred <= rdata[ADDR_W-1:0];
      OP_RM_NEXT:  lnext <= rdata[ADDR_W-1:0];
      OP_PU_CLS:   xc <= class_of(rsize);
      OP_PU_LINK:  lnext <= head_rd;
      OP_PL_SZ: begin
        size <= rsize;
        x    <= bp;
      end
      OP_PL_HDR:   res <= bp;
      OP_PL_R_FTR: x <= off(WALK_W'(bp), WALK_W'(asize), '0);
      OP_WK_CHK: begin
        s <= rsize;
        if (!flags.hit && !flags.s_zero) p <= p + WALK_W'(rsize);
      end
      OP_FR_FTR:   bp <= aaddr;
      OP_OUT: begin
        out_item.result_addr <= res;
        out_item.status      <= stat;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/sfla_ctrl.sv -----
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences allocate and free commands as datapath micro-operations, with
// shared list-remove, list-push and merge routines entered by return state.
// ----------------------------------------------------------------------------
module sfla_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output sfla_pkg::cmd_t     cmd,
  input  sfla_pkg::flags_t   flags
);
  import sfla_pkg::*;

  typedef enum logic [5:0] {
    S_INIT, S_IDLE, S_DISP, S_IGN, S_OOM,
    S_FIT_HEAD, S_FIT_TEST, S_FIT_CHK, S_FIT_NEXT,
    S_GROW_SIZE, S_GROW_CHK, S_GROW_HDR, S_GROW_FTR, S_GROW_EPI,
    S_MRG_RD, S_MRG_SZ, S_MRG_PT, S_MRG_NX, S_MRG_PV, S_MRG_HDR, S_MRG_FTR,
    S_RM_RD, S_RM_CLS, S_RM_PRED, S_RM_NEXT, S_RM_BACK,
    S_PU_RD, S_PU_CLS, S_PU_LINK, S_PU_BACK,
    S_PL_RD, S_PL_SZ, S_PL_HDR, S_PL_A_FTR, S_PL_R_HDR, S_PL_R_FTR, S_PL_W_FTR,
    S_WK_TEST, S_WK_CHK, S_FR_HDR, S_FR_FTR, S_OUT
  } state_t;

  state_t            state, state_next;
  state_t            rm_ret, rm_ret_next;
  state_t            pu_ret, pu_ret_next;
  state_t            mg_ret, mg_ret_next;
  logic [INIT_W-1:0] step, step_next;
  logic              out_valid_next;

  assign in_stall = (state != S_IDLE);

  // Next state, return states and the command for this cycle.
  always_comb begin
    state_next     = state;
    rm_ret_next    = rm_ret;
    pu_ret_next    = pu_ret;
    mg_ret_next    = mg_ret;
    step_next      = step;
    cmd.op         = OP_NOP;
    cmd.init_step  = step;
    out_valid_next = out_valid & out_stall;
    unique case (state)
      S_INIT: begin
        cmd.op    = OP_INIT;
        step_next = step + INIT_W'(1);
        if (step == INIT_W'(INIT_LEN - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (flags.is_free) state_next = flags.addr_zero ? S_IGN : S_WK_TEST;
        else               state_next = flags.req_zero ? S_IGN : S_FIT_HEAD;
      end
      S_IGN: begin
        cmd.op     = OP_IGNORE;
        state_next = S_OUT;
      end
      S_OOM: begin
        cmd.op     = OP_OOM;
        state_next = S_OUT;
      end
      // First-fit search over the class lists.
      S_FIT_HEAD: begin
        cmd.op     = OP_FIT_HEAD;
        state_next = S_FIT_TEST;
      end
      S_FIT_TEST: begin
        cmd.op = OP_FIT_TEST;
        priority if (!flags.p_zero) state_next = S_FIT_CHK;
        else if (flags.cls_last)    state_next = S_GROW_SIZE;
        else                        state_next = S_FIT_HEAD;
      end
      S_FIT_CHK: begin
        cmd.op     = OP_FIT_CHK;
        state_next = flags.fit_ok ? S_PL_RD : S_FIT_NEXT;
      end
      S_FIT_NEXT: begin
        cmd.op     = OP_FIT_NEXT;
        state_next = S_FIT_TEST;
      end
      // Heap growth.
      S_GROW_SIZE: begin
        cmd.op     = OP_GROW_SIZE;
        state_next = S_GROW_CHK;
      end
      S_GROW_CHK:  state_next = flags.oom ? S_OOM : S_GROW_HDR;
      S_GROW_HDR: begin
        cmd.op     = OP_GROW_HDR;
        state_next = S_GROW_FTR;
      end
      S_GROW_FTR: begin
        cmd.op     = OP_GROW_FTR;
        state_next = S_GROW_EPI;
      end
      S_GROW_EPI: begin
        cmd.op      = OP_GROW_EPI;
        mg_ret_next = S_PL_RD;
        state_next  = S_MRG_RD;
      end
      // Merge with free neighbors, then push onto its list.
      S_MRG_RD: begin
        cmd.op     = OP_MRG_RD;
        state_next = S_MRG_SZ;
      end
      S_MRG_SZ: begin
        cmd.op     = OP_MRG_SZ;
        state_next = S_MRG_PT;
      end
      S_MRG_PT: begin
        cmd.op     = OP_MRG_PT;
        state_next = S_MRG_NX;
      end
      S_MRG_NX: begin
        cmd.op = OP_MRG_NX;
        if (flags.next_free) begin
          rm_ret_next = S_MRG_PV;
          state_next  = S_RM_RD;
        end else begin
          state_next = S_MRG_PV;
        end
      end
      S_MRG_PV: begin
        cmd.op = OP_MRG_PV;
        if (flags.prev_free) begin
          rm_ret_next = S_MRG_HDR;
          state_next  = S_RM_RD;
        end else begin
          state_next = S_MRG_HDR;
        end
      end
      S_MRG_HDR: begin
        cmd.op     = OP_MRG_HDR;
        state_next = S_MRG_FTR;
      end
      S_MRG_FTR: begin
        cmd.op      = OP_MRG_FTR;
        pu_ret_next = mg_ret;
        state_next  = S_PU_RD;
      end
      // Unlink a block from its class list.
      S_RM_RD: begin
        cmd.op     = OP_RM_RD;
        state_next = S_RM_CLS;
      end
      S_RM_CLS: begin
        cmd.op     = OP_RM_CLS;
        state_next = S_RM_PRED;
      end
      S_RM_PRED: begin
        cmd.op     = OP_RM_PRED;
        state_next = S_RM_NEXT;
      end
      S_RM_NEXT: begin
        cmd.op     = OP_RM_NEXT;
        state_next = S_RM_BACK;
      end
      S_RM_BACK: begin
        cmd.op     = OP_RM_BACK;
        state_next = rm_ret;
      end
      // Push a block at the head of its class list.
      S_PU_RD: begin
        cmd.op     = OP_PU_RD;
        state_next = S_PU_CLS;
      end
      S_PU_CLS: begin
        cmd.op     = OP_PU_CLS;
        state_next = S_PU_LINK;
      end
      S_PU_LINK: begin
        cmd.op     = OP_PU_LINK;
        state_next = S_PU_BACK;
      end
      S_PU_BACK: begin
        cmd.op     = OP_PU_BACK;
        state_next = pu_ret;
      end
      // Place the request in the chosen block, splitting off the rest when it is large enough.
      S_PL_RD: begin
        cmd.op     = OP_PL_RD;
        state_next = S_PL_SZ;
      end
      S_PL_SZ: begin
        cmd.op      = OP_PL_SZ;
        rm_ret_next = S_PL_HDR;
        state_next  = S_RM_RD;
      end
      S_PL_HDR: begin
        cmd.op     = OP_PL_HDR;
        state_next = flags.split ? S_PL_A_FTR : S_PL_W_FTR;
      end
      S_PL_A_FTR: begin
        cmd.op     = OP_PL_A_FTR;
        state_next = S_PL_R_HDR;
      end
      S_PL_R_HDR: begin
        cmd.op     = OP_PL_R_HDR;
        state_next = S_PL_R_FTR;
      end
      S_PL_R_FTR: begin
        cmd.op      = OP_PL_R_FTR;
        pu_ret_next = S_OUT;
        state_next  = S_PU_RD;
      end
      S_PL_W_FTR: begin
        cmd.op     = OP_PL_W_FTR;
        state_next = S_OUT;
      end
      // Free: walk the blocks from the first one to validate the address.
      S_WK_TEST: begin
        cmd.op     = OP_WK_TEST;
        state_next = flags.p_end ? S_IGN : S_WK_CHK;
      end
      S_WK_CHK: begin
        cmd.op = OP_WK_CHK;
        priority if (flags.hit && flags.hit_alloc) state_next = S_FR_HDR;
        else if (flags.hit || flags.s_zero)        state_next = S_IGN;
        else                                       state_next = S_WK_TEST;
      end
      S_FR_HDR: begin
        cmd.op     = OP_FR_HDR;
        state_next = S_FR_FTR;
      end
      S_FR_FTR: begin
        cmd.op      = OP_FR_FTR;
        mg_ret_next = S_OUT;
        state_next  = S_MRG_RD;
      end
      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.op         = OP_OUT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, return states and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      rm_ret    <= S_IDLE;
      pu_ret    <= S_IDLE;
      mg_ret    <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rm_ret    <= rm_ret_next;
      pu_ret    <= pu_ret_next;
      mg_ret    <= mg_ret_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/sfla_checker.sv -----
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the top-level ports for reset, busy and result consistency.
// ----------------------------------------------------------------------------
module sfla_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input sfla_pkg::out_item_t out_item
);
  import sfla_pkg::*;

  // Reset starts the heap init, so input stalls and no result shows.
  a_reset: assert property (@(posedge clk) rst |=> in_stall && !out_valid)
    else $error("busy or valid wrong after reset");

  // A waiting result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Failed or ignored commands return no address.
  a_fail_null: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_DONE |-> out_item.result_addr == '0 &&
      (out_item.status == ST_OOM || out_item.status == ST_IGNORED))
    else $error("bad status or address on failure");

  // Allocated payloads are 8-byte aligned and past the prologue.
  a_align: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.result_addr != '0 |->
      out_item.result_addr[2:0] == 3'b000 && out_item.result_addr >= FIRST_PAYLOAD)
    else $error("misaligned result address");

  // One command at a time: an accepted item makes the block busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a second item while busy");

endmodule

bind segregated_free_list_allocator sfla_checker u_sfla_checker (.*);

// ----- dv/segregated_free_list_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// Segregated free-list allocator testbench
// Drives allocate and free items with random gaps and output stalls, keeps its
// own model of the heap words, class lists and heap end, and compares every
// result item with the predicted one. The grow chunk register is swept
// through its extremes and through odd values between phases.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator_tb;
  import sfla_pkg::*;

  localparam int unsigned MODEL_HEAP_BYTES = HEAP_WORDS * 4;
  localparam int unsigned CYCLE_LIMIT      = 6000000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 cfg_wr_en;
  logic [CHUNK_W-1:0]   cfg_wr_data;

  segregated_free_list_allocator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Heap model state.
  logic [31:0]  heap_words [HEAP_WORDS];
  int unsigned  list_heads [NUM_CLASSES];
  int unsigned  heap_top;
  int unsigned  chunk_bytes;

  out_item_t    pending_results [$];
  int unsigned  live_blocks [$];
  int unsigned  freed_blocks [$];
  int           error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  stall_left;
  bit           quiet_phase;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Heap model
  // ---------------------------------------------------------------------------
  function automatic int unsigned word_at(input int unsigned a);
    return heap_words[(a >> 2) % HEAP_WORDS];
  endfunction

  function automatic void word_put(input int unsigned a, input int unsigned v);
    heap_words[(a >> 2) % HEAP_WORDS] = v;
  endfunction

  function automatic int unsigned size_at(input int unsigned bp);
    return word_at(bp - 4) & ~32'd7;
  endfunction

  function automatic int unsigned taken_at(input int unsigned bp);
    return word_at(bp - 4) & 32'd1;
  endfunction

  function automatic void put_tags(input int unsigned bp, input int unsigned sz,
                                   input int unsigned taken);
    word_put(bp - 4, sz | taken);
    word_put(bp + sz - 8, sz | taken);
  endfunction

  function automatic int unsigned size_class(input int unsigned sz);
    for (int i = 0; i < NUM_CLASSES - 1; i++) begin
      if (sz <= CLASS_LIMIT[i]) return i;
    end
    return NUM_CLASSES - 1;
  endfunction

  function automatic void list_link(input int unsigned bp);
    int unsigned c;
    int unsigned h;
    c = size_class(size_at(bp));
    h = list_heads[c];
    word_put(bp, 0);
    word_put(bp + 4, h);
    if (h != 0) word_put(h, bp);
    list_heads[c] = bp;
  endfunction

  function automatic void list_unlink(input int unsigned bp);
    int unsigned c;
    int unsigned pred;
    int unsigned succ;
    c = size_class(size_at(bp));
    pred = word_at(bp);
    succ = word_at(bp + 4);
    if (pred == 0) list_heads[c] = succ;
    else word_put(pred + 4, succ);
    if (succ != 0) word_put(succ, pred);
  endfunction

  function automatic int unsigned coalesce(input int unsigned bp_in);
    int unsigned bp;
    int unsigned sz;
    int unsigned prev_tag;
    int unsigned nxt;
    int unsigned prv;
    bp = bp_in;
    sz = size_at(bp);
    prev_tag = word_at(bp - 8);
    nxt = bp + sz;
    if (taken_at(nxt) == 0) begin
      list_unlink(nxt);
      sz += size_at(nxt);
    end
    if ((prev_tag & 1) == 0) begin
      prv = bp - (prev_tag & ~32'd7);
      list_unlink(prv);
      sz += size_at(prv);
      bp = prv;
    end
    put_tags(bp, sz, 0);
    list_link(bp);
    return bp;
  endfunction

  function automatic int unsigned grow_heap(input int unsigned bytes);
    int unsigned bp;
    bp = heap_top;
    put_tags(bp, bytes, 0);
    word_put(bp + bytes - 4, 1);
    heap_top += bytes;
    return coalesce(bp);
  endfunction

  function automatic int unsigned first_fit(input int unsigned asize);
    int unsigned p;
    for (int unsigned c = size_class(asize); c < NUM_CLASSES; c++) begin
      for (p = list_heads[c]; p != 0; p = word_at(p + 4)) begin
        if (size_at(p) >= asize) return p;
      end
    end
    return 0;
  endfunction

  function automatic void carve(input int unsigned bp, input int unsigned asize);
    int unsigned total;
    total = size_at(bp);
    list_unlink(bp);
    if (total - asize >= 24) begin
      put_tags(bp, asize, 1);
      put_tags(bp + asize, total - asize, 0);
      list_link(bp + asize);
    end else begin
      put_tags(bp, total, 1);
    end
  endfunction

  function automatic void heap_model_reset();
    foreach (heap_words[i]) heap_words[i] = '0;
    foreach (list_heads[i]) list_heads[i] = 0;
    chunk_bytes = RESET_CHUNK;
    word_put(4, 9);
    word_put(8, 9);
    word_put(12, 1);
    heap_top = FIRST_PAYLOAD;
    void'(grow_heap(chunk_bytes));
  endfunction

  // Works out the result item that one command produces and updates the model.
  function automatic out_item_t heap_model_apply(input in_item_t cmd);
    out_item_t   res;
    int unsigned asize;
    int unsigned bp;
    int unsigned g;
    int unsigned a;
    int unsigned p;
    int unsigned s;
    res.result_addr = '0;
    res.status = ST_DONE;
    if (cmd.opcode == OPC_ALLOC) begin
      if (cmd.req_size == 0) begin
        res.status = ST_IGNORED;
      end else begin
        asize = (int'(cmd.req_size) + 15) & ~32'd7;
        if (asize < 24) asize = 24;
        bp = first_fit(asize);
        if (bp == 0) begin
          g = (asize > chunk_bytes) ? asize : chunk_bytes;
          g = ((g & ~32'd3) + 7) & ~32'd7;
          if (g > MODEL_HEAP_BYTES - heap_top) res.status = ST_OOM;
          else bp = grow_heap(g);
        end
        if (bp != 0) begin
          carve(bp, asize);
          res.result_addr = bp[ADDR_W-1:0];
        end
      end
    end else begin
      a = cmd.block_addr;
      p = FIRST_PAYLOAD;
      s = 0;
      while (a != 0 && p < heap_top) begin
        s = size_at(p);
        if (p == a || s == 0) break;
        p += s;
      end
      if (a == 0 || p != a || p >= heap_top || taken_at(p) == 0) begin
        res.status = ST_IGNORED;
      end else begin
        put_tags(a, s, 0);
        void'(coalesce(a));
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned gap_cycles();
    int unsigned r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sends one item, waits for it to be taken and records the predicted result.
  task automatic send_item(input logic op, input int unsigned sz, input int unsigned addr,
                           output out_item_t predicted);
    in_item_t cmd;
    cmd.opcode = op;
    cmd.req_size = sz[ADDR_W-1:0];
    cmd.block_addr = addr[ADDR_W-1:0];
    in_item = cmd;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = heap_model_apply(cmd);
    pending_results.push_back(predicted);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (gap_cycles()) @(negedge clk);
  endtask

  task automatic alloc_item(input int unsigned sz);
    out_item_t r;
    send_item(OPC_ALLOC, sz, $urandom_range(0, 262143), r);
    if (r.status == ST_DONE) live_blocks.push_back(r.result_addr);
  endtask

  task automatic free_item(input int unsigned addr);
    out_item_t r;
    send_item(OPC_FREE, $urandom_range(0, 262143), addr, r);
    if (r.status == ST_DONE) begin
      freed_blocks.push_back(addr);
      if (freed_blocks.size() > 32) void'(freed_blocks.pop_front());
    end
  endtask

  task automatic free_random_live();
    int unsigned k;
    int unsigned addr;
    k = $urandom_range(0, live_blocks.size() - 1);
    addr = live_blocks[k];
    live_blocks.delete(k);
    free_item(addr);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // The register is only written once the block has gone quiet.
  task automatic write_chunk(input int unsigned value);
    drain();
    repeat (60) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value[CHUNK_W-1:0];
    @(negedge clk);
    cfg_wr_en = 1'b0;
    chunk_bytes = value & 32'h1FFFF;
  endtask

  function automatic int unsigned random_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return 0;
    if (r < 68) return $urandom_range(1, 64);
    if (r < 90) return $urandom_range(65, 1000);
    if (r < 99) return $urandom_range(1001, 8000);
    return $urandom_range(8001, 262143);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes of the fields and each special case.
  task automatic test_directed();
    int unsigned a;
    int unsigned b;
    int unsigned c;
    out_item_t   r;
    quiet_phase = 1'b1;
    send_item(OPC_ALLOC, 0, 262143, r);
    send_item(OPC_FREE, 262143, 0, r);
    send_item(OPC_ALLOC, 262143, 0, r);
    send_item(OPC_FREE, 0, 262143, r);
    alloc_item(1);
    alloc_item(16);
    alloc_item(17);
    alloc_item(2040);
    a = live_blocks[0];
    send_item(OPC_FREE, 0, a + 8, r);
    // Neighbors freed on both sides before the middle block.
    alloc_item(100);
    alloc_item(200);
    alloc_item(300);
    c = live_blocks.pop_back();
    b = live_blocks.pop_back();
    a = live_blocks.pop_back();
    free_item(a);
    free_item(c);
    free_item(b);
    free_item(b);
    while (live_blocks.size() != 0) free_item(live_blocks.pop_front());
    quiet_phase = 1'b0;
  endtask

  // Growth under several chunk settings, the extremes and odd values.
  task automatic test_chunk_settings();
    int unsigned values [6] = '{24, 13, 65536, 131071, 1001, 2048};
    foreach (values[v]) begin
      write_chunk(values[v]);
      repeat (12) alloc_item($urandom_range(1, 3000));
      while (live_blocks.size() != 0) free_random_live();
    end
  endtask

  // Random mix of allocate and free with some bad frees.
  task automatic test_random_mix(input int unsigned count);
    int unsigned r;
    repeat (count) begin
      if ($urandom_range(0, 299) == 0) quiet_phase = ~quiet_phase;
      r = $urandom_range(0, 99);
      if (live_blocks.size() == 0 || (r < 55 && live_blocks.size() < 120)) begin
        alloc_item(random_size());
      end else if (r < 92 || live_blocks.size() >= 120) begin
        free_random_live();
      end else if (r < 95 && freed_blocks.size() != 0) begin
        free_item(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
      end else if (r < 97) begin
        free_item(live_blocks[$urandom_range(0, live_blocks.size() - 1)] + 8);
      end else begin
        free_item($urandom_range(0, 262143));
      end
    end
    quiet_phase = 1'b0;
  endtask

  // Fill the heap with large blocks until growth runs past the bound.
  task automatic test_heap_exhaust();
    int unsigned oom_seen;
    out_item_t   r;
    write_chunk(65536);
    oom_seen = 0;
    while (oom_seen < 4) begin
      send_item(OPC_ALLOC, $urandom_range(20000, 70000), 0, r);
      if (r.status == ST_DONE) live_blocks.push_back(r.result_addr);
      else oom_seen++;
    end
    repeat (10) alloc_item($urandom_range(1, 200));
    while (live_blocks.size() != 0) free_random_live();
    write_chunk(2048);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item addr=%0d status=%0d", $time,
                 out_item.result_addr, out_item.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.result_addr !== want.result_addr) begin
          $display("%0t: result_addr expected %0d actual %0d", $time,
                   want.result_addr, out_item.result_addr);
          error_count++;
        end
        if (out_item.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_item.status);
          error_count++;
        end
      end
    end
  end

  // Receiver stalls: mostly short, now and then a long stretch, none in quiet phases.
  always @(negedge clk) begin
    if (quiet_phase) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 3) begin
      stall_left = $urandom_range(8, 40);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    quiet_phase = 1'b0;
    heap_model_reset();
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_chunk_settings();
    test_random_mix(1150);
    test_heap_exhaust();
    test_random_mix(120);
    while (live_blocks.size() != 0) free_random_live();
    drain();
    repeat (200) @(negedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
